// ----- sv/cfm_pkg.sv -----
// Shared constants and status codes for the capture frequency meter.
`timescale 1ns / 1ps
package cfm_pkg;

  localparam int CNT_W      = 7;   // capture_count and window counter
  localparam int STAMP_W    = 32;  // timestamp and mean period
  localparam int FREQ_W     = 16;
  localparam int RELOAD_W   = 15;
  localparam int STATUS_W   = 2;

  // One counter tick is 3.34 us: f = 1e8 / (334 * mean)
  localparam int SCALE_W    = 9;
  localparam logic [SCALE_W-1:0] TICK_SCALE = SCALE_W'(334);
  localparam int PROD_W     = STAMP_W + SCALE_W;

  localparam int FREQ_NUM_W = 27;
  localparam logic [FREQ_NUM_W-1:0] FREQ_NUM = FREQ_NUM_W'(100000000);
  localparam int RELOAD_NUM_W = 17;
  localparam logic [RELOAD_NUM_W-1:0] RELOAD_NUM = RELOAD_NUM_W'(120000);

  localparam logic [FREQ_W-1:0]   FREQ_SAT   = FREQ_W'(65535);
  localparam logic [RELOAD_W-1:0] RELOAD_MIN = RELOAD_W'(25);
  localparam logic [RELOAD_W-1:0] RELOAD_MAX = RELOAD_W'(30000);

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd2;

endpackage

// ----- sv/cfm_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by the back end.
`timescale 1ns / 1ps
module cfm_div
  import cfm_pkg::*;
#(
  parameter int DW = 38,
  parameter int SW = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DW-1:0]     dividend,   // left-aligned to DW
  input  logic [PROD_W-1:0] divisor,
  input  logic [SW-1:0]     steps,
  output logic              done,
  output logic [DW-1:0]     quotient
);

  logic [DW-1:0]     q_r, q_nxt;
  logic [PROD_W-1:0] rem_r, rem_nxt;
  logic [PROD_W-1:0] dvs_r, dvs_nxt;
  logic [SW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [PROD_W:0]   rem_sh;
  logic [PROD_W:0]   rem_sub;
  logic              ge;

  always_comb begin
    rem_sh  = {rem_r, q_r[DW-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_sub = rem_sh - {1'b0, dvs_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[DW-2:0], ge};
      rem_nxt = ge ? rem_sub[PROD_W-1:0] : rem_sh[PROD_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == SW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ----- sv/cfm_queue.sv -----
// Two-entry queue of closed windows between front and back end.
`timescale 1ns / 1ps
module cfm_queue #(
  parameter int W = 45
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("pop from empty queue");

endmodule

// ----- sv/cfm_front.sv -----
// Front end: takes timestamps, sums wrapping periods, closes windows.
`timescale 1ns / 1ps
module cfm_front
  import cfm_pkg::*;
#(
  parameter int MAX_CAPTURES = 64,
  parameter int SUM_W = 38
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [CNT_W-1:0]       capture_count,
  input  logic                   in_valid,
  input  logic [STAMP_W-1:0]     in_timestamp,
  output logic                   in_stall,
  input  logic                   q_full,
  output logic                   push,
  output logic [SUM_W+CNT_W-1:0] push_data
);

  logic [STAMP_W-1:0] last_stamp_r, last_stamp_nxt;
  logic [CNT_W-1:0]   seen_r, seen_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [CNT_W-1:0]   n_eff, seen_inc;
  logic [STAMP_W-1:0] diff;
  logic [SUM_W-1:0]   sum_add;
  logic               accept, close;

  always_comb begin
    priority if (capture_count < CNT_W'(2)) n_eff = CNT_W'(2);
    else if (int'(capture_count) > MAX_CAPTURES) n_eff = CNT_W'(MAX_CAPTURES);
    else n_eff = capture_count;

    accept   = in_valid && !q_full;
    diff     = in_timestamp - last_stamp_r;
    sum_add  = (seen_r != '0) ? sum_r + SUM_W'(diff) : sum_r;
    seen_inc = seen_r + 1'b1;
    close    = accept && (seen_inc >= n_eff);

    last_stamp_nxt = last_stamp_r;
    seen_nxt       = seen_r;
    sum_nxt        = sum_r;
    if (accept) begin
      last_stamp_nxt = in_timestamp;
      // start a fresh window once the count is reached
      seen_nxt = close ? '0 : seen_inc;
      sum_nxt  = close ? '0 : sum_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_stamp_r <= '0;
      seen_r       <= '0;
      sum_r        <= '0;
    end else begin
      last_stamp_r <= last_stamp_nxt;
      seen_r       <= seen_nxt;
      sum_r        <= sum_nxt;
    end
  end

  assign in_stall  = q_full;
  assign push      = close;
  assign push_data = {sum_add, n_eff - 1'b1};

endmodule

// ----- sv/cfm_back.sv -----
// Back end: mean, frequency and reload through the shared divider.
`timescale 1ns / 1ps
module cfm_back
  import cfm_pkg::*;
#(
  parameter int SUM_W = 38
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [SUM_W+CNT_W-1:0] q_head,
  input  logic                   q_empty,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [STAMP_W-1:0]     out_mean_period,
  output logic [FREQ_W-1:0]      out_frequency_hz,
  output logic [RELOAD_W-1:0]    out_sample_reload,
  output logic [STATUS_W-1:0]    out_status
);

  localparam int DW = SUM_W;
  localparam int SW = $clog2(DW + 1);
  localparam logic [DW-1:0] FREQ_DIVIDEND   = DW'(FREQ_NUM) << (DW - FREQ_NUM_W);
  localparam logic [DW-1:0] RELOAD_DIVIDEND = DW'(RELOAD_NUM) << (DW - RELOAD_NUM_W);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MEAN   = 6'b000010,
    ST_MUL    = 6'b000100,
    ST_FREQ   = 6'b001000,
    ST_RELOAD = 6'b010000,
    ST_OUT    = 6'b100000
  } back_state_t;

  back_state_t          state_r, state_nxt;
  logic [STAMP_W-1:0]   mean_r, mean_nxt;
  logic [FREQ_W-1:0]    freq_r, freq_nxt;
  logic [RELOAD_W-1:0]  reload_r, reload_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [STAMP_W-1:0]   out_mean_r;
  logic [FREQ_W-1:0]    out_freq_r;
  logic [RELOAD_W-1:0]  out_reload_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic                 out_load;

  logic                 div_start, div_done;
  logic [DW-1:0]        div_dividend, div_quo;
  logic [PROD_W-1:0]    div_divisor;
  logic [SW-1:0]        div_steps;

  cfm_div #(.DW(DW), .SW(SW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt    = state_r;
    mean_nxt     = mean_r;
    freq_nxt     = freq_r;
    reload_nxt   = reload_r;
    status_nxt   = status_r;
    q_pop        = 1'b0;
    out_load     = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    div_steps    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop        = 1'b1;
          div_start    = 1'b1;
          div_dividend = q_head[SUM_W+CNT_W-1:CNT_W];
          div_divisor  = PROD_W'(q_head[CNT_W-1:0]);
          div_steps    = SW'(DW);
          state_nxt    = ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (div_done) begin
          mean_nxt = div_quo[STAMP_W-1:0];
          if (div_quo[STAMP_W-1:0] == '0) begin
            freq_nxt     = FREQ_SAT;
            status_nxt   = STATUS_ZERO;
            div_start    = 1'b1;
            div_dividend = RELOAD_DIVIDEND;
            div_divisor  = PROD_W'(FREQ_SAT);
            div_steps    = SW'(RELOAD_NUM_W);
            state_nxt    = ST_RELOAD;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        // product lands in the divider's divisor register
        div_start    = 1'b1;
        div_dividend = FREQ_DIVIDEND;
        div_divisor  = PROD_W'(mean_r) * PROD_W'(TICK_SCALE);
        div_steps    = SW'(FREQ_NUM_W);
        state_nxt    = ST_FREQ;
      end
      ST_FREQ: begin
        if (div_done) begin
          if (div_quo[DW-1:FREQ_W] != '0) begin
            freq_nxt   = FREQ_SAT;
            status_nxt = STATUS_SAT;
          end else begin
            freq_nxt   = div_quo[FREQ_W-1:0];
            status_nxt = STATUS_OK;
          end
          if (freq_nxt == '0) begin
            reload_nxt = RELOAD_MAX;
            state_nxt  = ST_OUT;
          end else begin
            div_start    = 1'b1;
            div_dividend = RELOAD_DIVIDEND;
            div_divisor  = PROD_W'(freq_nxt);
            div_steps    = SW'(RELOAD_NUM_W);
            state_nxt    = ST_RELOAD;
          end
        end
      end
      ST_RELOAD: begin
        if (div_done) begin
          priority if (div_quo < DW'(RELOAD_MIN)) reload_nxt = RELOAD_MIN;
          else if (div_quo > DW'(RELOAD_MAX)) reload_nxt = RELOAD_MAX;
          else reload_nxt = div_quo[RELOAD_W-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    mean_r   <= mean_nxt;
    freq_r   <= freq_nxt;
    reload_r <= reload_nxt;
    status_r <= status_nxt;
    if (out_load) begin
      out_mean_r   <= mean_r;
      out_freq_r   <= freq_r;
      out_reload_r <= reload_r;
      out_status_r <= status_r;
    end
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mean_period   = out_mean_r;
  assign out_frequency_hz  = out_freq_r;
  assign out_sample_reload = out_reload_r;
  assign out_status        = out_status_r;

  a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result shown without passing the output state");
  a_zero_mean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STATUS_ZERO) |->
      (out_mean_r == '0 && out_freq_r == FREQ_SAT && out_reload_r == RELOAD_MIN))
    else $error("zero-mean result inconsistent");

endmodule

// ----- sv/capture_frequency_meter.sv -----
// Top level of the capture frequency meter: config register, front, queue, back.
//
//  channel | direction | handshake           | beat payload
//  in_     | input     | in_valid / in_stall | in_timestamp
//  out_    | output    | out_valid/out_stall | mean_period, frequency_hz, sample_reload, status
//  cfg_    | input     | cfg_wr_en           | cfg_wr_data (capture_count)
//
// The front takes one timestamp beat per cycle unless the queue is full; a closing beat is taken too.
// The back end takes one window at a time through mean, product, frequency and reload steps on the
// bit-serial divider, then output; a zero mean skips the product and the frequency division.
// Two closed windows can wait in the queue; in_stall rises only when it is full.
// Reset is synchronous, active low; capture_count returns to 16, no clearing pass.
`timescale 1ns / 1ps
module capture_frequency_meter
  import cfm_pkg::*;
#(
  parameter int MAX_CAPTURES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CNT_W-1:0]     cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [STAMP_W-1:0]   in_timestamp,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STAMP_W-1:0]   out_mean_period,
  output logic [FREQ_W-1:0]    out_frequency_hz,
  output logic [RELOAD_W-1:0]  out_sample_reload,
  output logic [STATUS_W-1:0]  out_status
);

  localparam int SUM_W   = STAMP_W + $clog2(MAX_CAPTURES);
  localparam int ENTRY_W = SUM_W + CNT_W;

  logic [CNT_W-1:0]   capture_count_r, capture_count_nxt;
  logic               q_push, q_pop, q_full, q_empty;
  logic [ENTRY_W-1:0] q_push_data, q_head;

  always_comb begin
    capture_count_nxt = cfg_wr_en ? cfg_wr_data : capture_count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) capture_count_r <= CNT_W'(16);
    else capture_count_r <= capture_count_nxt;
  end

  cfm_front #(.MAX_CAPTURES(MAX_CAPTURES), .SUM_W(SUM_W)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .capture_count (capture_count_r),
    .in_valid      (in_valid),
    .in_timestamp  (in_timestamp),
    .in_stall      (in_stall),
    .q_full        (q_full),
    .push          (q_push),
    .push_data     (q_push_data)
  );

  cfm_queue #(.W(ENTRY_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  cfm_back #(.SUM_W(SUM_W)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_head            (q_head),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mean_period   (out_mean_period),
    .out_frequency_hz  (out_frequency_hz),
    .out_sample_reload (out_sample_reload),
    .out_status        (out_status)
  );

endmodule
